// ===== design/mlkr_pkg.sv =====
// Shared types, keycodes and helpers for the modifier layer key remapper.
package mlkr_pkg;

  // Event types
  localparam logic [4:0] EV_KEY = 5'd1;
  localparam logic [4:0] EV_MSC = 5'd4;
  localparam logic [9:0] MSC_SCAN = 10'd4;

  // Keycodes
  localparam logic [9:0] KC_ESC    = 10'd1;
  localparam logic [9:0] KC_LCTRL  = 10'd29;
  localparam logic [9:0] KC_LSHIFT = 10'd42;
  localparam logic [9:0] KC_RSHIFT = 10'd54;
  localparam logic [9:0] KC_LALT   = 10'd56;
  localparam logic [9:0] KC_CAPS   = 10'd58;
  localparam logic [9:0] KC_RCTRL  = 10'd97;
  localparam logic [9:0] KC_RALT   = 10'd100;
  localparam logic [9:0] KC_HOME   = 10'd102;
  localparam logic [9:0] KC_UP     = 10'd103;
  localparam logic [9:0] KC_PGUP   = 10'd104;
  localparam logic [9:0] KC_LEFT   = 10'd105;
  localparam logic [9:0] KC_RIGHT  = 10'd106;
  localparam logic [9:0] KC_END    = 10'd107;
  localparam logic [9:0] KC_DOWN   = 10'd108;
  localparam logic [9:0] KC_PGDN   = 10'd109;
  localparam logic [9:0] KC_LMETA  = 10'd125;
  localparam logic [9:0] KC_RMETA  = 10'd126;

  // Key values
  localparam logic signed [31:0] VAL_RELEASE = 32'sd0;
  localparam logic signed [31:0] VAL_PRESS   = 32'sd1;
  localparam logic signed [31:0] VAL_REPEAT  = 32'sd2;

  // Configuration register indexes
  localparam logic REG_META_MODE = 1'b0;
  localparam logic REG_CAPS_EN   = 1'b1;

  // Meta blocking modes
  localparam logic [1:0] MODE_PASS    = 2'd0;
  localparam logic [1:0] MODE_SWALLOW = 2'd1;
  localparam logic [1:0] MODE_LAZY    = 2'd2;
  localparam logic [1:0] MODE_ALIAS   = 2'd3;

  // Results held per input item
  localparam int unsigned MaxRes = 3;

  typedef struct packed {
    logic [4:0]         ev_type;
    logic [9:0]         ev_code;
    logic signed [31:0] ev_value;
  } ev_t;

  function automatic ev_t make_ev(logic [4:0] t, logic [9:0] c, logic signed [31:0] v);
    ev_t e;
    e.ev_type  = t;
    e.ev_code  = c;
    e.ev_value = v;
    return e;
  endfunction

  function automatic logic is_modifier(logic [9:0] c);
    return (c == KC_LSHIFT) || (c == KC_RSHIFT) || (c == KC_LALT) ||
           (c == KC_RALT) || (c == KC_LMETA) || (c == KC_RMETA) ||
           (c == KC_LCTRL) || (c == KC_RCTRL);
  endfunction

endpackage

// ===== design/modifier_layer_key_remapper.sv =====
// Top level of the modifier layer key remapper: decode, state update and result buffer.
//
// Usage:
// - Input channel (in_valid_i/in_ready_o) carries one event item: type, code, value.
// - Output channel (out_valid_o/out_ready_i) returns zero to three remapped events per
//   input item; last_of_run_o marks the final event of the run.
// - Config channel (cfg_valid_i/cfg_ready_o) writes register 0 (meta blocking mode,
//   2 bits) or register 1 (caps layer enable, bit 0). Always ready; write only while idle.
// Output: the first result of an item is registered and appears in the cycle after it is accepted.
// Throughput: the result buffer drains one event per cycle while out_ready_i is high. A new
//   item is accepted in the same cycle the last result of the previous one is taken;
//   items that make no result can be accepted every cycle.
// Reset: all modifier state clears, mode resets to swallow-and-replay, caps layer off,
//   result buffer empty.
// Stall: while out_ready_i is low the current result holds, and in_ready_o stays low
//   until the buffered run is down to its last event being taken.
module modifier_layer_key_remapper
  import mlkr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [1:0]         cfg_data_i,
  // input event channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [4:0]         event_type_i,
  input  logic [9:0]         event_code_i,
  input  logic signed [31:0] event_value_i,
  // output event channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [4:0]         out_type_o,
  output logic [9:0]         out_code_o,
  output logic signed [31:0] out_value_o,
  output logic               last_of_run_o
);

  // Configuration registers
  logic [1:0] meta_mode_q;
  logic       caps_en_q;

  // Modifier state
  logic meta_held_q, meta_used_q, meta_inj_q, caps_held_q, caps_used_q;
  logic meta_held_d, meta_used_d, meta_inj_d, caps_held_d, caps_used_d;

  // Result buffer
  ev_t        buf_q [MaxRes];
  ev_t        ev_d  [MaxRes];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] idx_q;

  logic [1:0] mode;
  logic       in_acc, out_acc, is_last, is_arrow, pass_thru;
  logic [9:0] arrow_map;

  assign cfg_ready_o = 1'b1;

  // Latch configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_mode_q <= MODE_SWALLOW;
      caps_en_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_META_MODE: meta_mode_q <= cfg_data_i;
        REG_CAPS_EN:   caps_en_q   <= cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  // Output side of the buffer
  assign out_valid_o   = (cnt_q != 2'd0);
  assign is_last       = (idx_q == cnt_q - 2'd1);
  assign out_type_o    = buf_q[idx_q].ev_type;
  assign out_code_o    = buf_q[idx_q].ev_code;
  assign out_value_o   = buf_q[idx_q].ev_value;
  assign last_of_run_o = is_last;
  assign out_acc       = out_valid_o && out_ready_i;

  // Take a new item when the buffer is empty or its last event leaves now
  assign in_ready_o = (cnt_q == 2'd0) || (out_acc && is_last);
  assign in_acc     = in_valid_i && in_ready_o;

  // Decode arrow keys and their navigation targets
  assign mode     = (meta_mode_q == MODE_ALIAS) ? MODE_SWALLOW : meta_mode_q;
  assign is_arrow = (event_code_i == KC_LEFT) || (event_code_i == KC_RIGHT) ||
                    (event_code_i == KC_UP) || (event_code_i == KC_DOWN);

  always_comb begin
    case (event_code_i)
      KC_LEFT:  arrow_map = KC_HOME;
      KC_RIGHT: arrow_map = KC_END;
      KC_UP:    arrow_map = KC_PGUP;
      default:  arrow_map = KC_PGDN;
    endcase
  end

  // Remap one item into up to three events and the next modifier state
  always_comb begin
    meta_held_d = meta_held_q;
    meta_used_d = meta_used_q;
    meta_inj_d  = meta_inj_q;
    caps_held_d = caps_held_q;
    caps_used_d = caps_used_q;
    cnt_d       = 2'd0;
    pass_thru   = 1'b0;
    for (int i = 0; i < MaxRes; i++) begin
      ev_d[i] = '0;
    end

    if (event_type_i == EV_MSC && event_code_i == MSC_SCAN) begin
      // drop scan codes
    end else if (event_type_i != EV_KEY) begin
      pass_thru = 1'b1;
    end else if (caps_en_q && caps_held_q) begin
      // caps layer active
      if (event_code_i == KC_CAPS) begin
        if (event_value_i == VAL_RELEASE) begin
          caps_held_d = 1'b0;
          if (caps_used_q) begin
            caps_used_d = 1'b0;
            ev_d[0] = make_ev(EV_KEY, KC_LCTRL, VAL_RELEASE);
            cnt_d   = 2'd1;
          end else begin
            ev_d[0] = make_ev(EV_KEY, KC_ESC, VAL_PRESS);
            ev_d[1] = make_ev(EV_KEY, KC_ESC, VAL_RELEASE);
            cnt_d   = 2'd2;
          end
        end
      end else if (event_code_i == KC_LCTRL) begin
        // swallow real ctrl while caps acts as ctrl
      end else if (event_code_i == KC_ESC) begin
        ev_d[0]     = make_ev(EV_KEY, KC_CAPS, event_value_i);
        cnt_d       = 2'd1;
        caps_used_d = 1'b1;
      end else if (!caps_used_q && event_value_i != VAL_RELEASE) begin
        caps_used_d = 1'b1;
        ev_d[0] = make_ev(EV_KEY, KC_LCTRL, VAL_PRESS);
        ev_d[1] = make_ev(event_type_i, event_code_i, event_value_i);
        cnt_d   = 2'd2;
      end else begin
        pass_thru = 1'b1;
      end
    end else if (caps_en_q && event_code_i == KC_CAPS && event_value_i == VAL_PRESS) begin
      caps_held_d = 1'b1;
    end else if (meta_held_q) begin
      // meta layer active
      if (event_code_i == KC_LMETA && event_value_i == VAL_RELEASE) begin
        meta_held_d = 1'b0;
        if (mode == MODE_PASS) begin
          ev_d[0] = make_ev(EV_KEY, KC_LMETA, VAL_RELEASE);
          cnt_d   = 2'd1;
        end else if (mode == MODE_LAZY && meta_inj_q) begin
          meta_inj_d = 1'b0;
          ev_d[0] = make_ev(EV_KEY, KC_LMETA, VAL_RELEASE);
          cnt_d   = 2'd1;
        end else if (!meta_used_q) begin
          ev_d[0] = make_ev(EV_KEY, KC_LMETA, VAL_PRESS);
          ev_d[1] = make_ev(EV_KEY, KC_LMETA, VAL_RELEASE);
          cnt_d   = 2'd2;
        end
      end else if (is_arrow && event_value_i == VAL_RELEASE) begin
        // drop arrow release, the tap already went out
      end else if (is_arrow &&
                   (event_value_i == VAL_PRESS || event_value_i == VAL_REPEAT)) begin
        meta_used_d = 1'b1;
        if (meta_inj_q) begin
          meta_inj_d = 1'b0;
          ev_d[0] = make_ev(EV_KEY, KC_LMETA, VAL_RELEASE);
          ev_d[1] = make_ev(EV_KEY, arrow_map, VAL_PRESS);
          ev_d[2] = make_ev(EV_KEY, arrow_map, VAL_RELEASE);
          cnt_d   = 2'd3;
        end else begin
          ev_d[0] = make_ev(EV_KEY, arrow_map, VAL_PRESS);
          ev_d[1] = make_ev(EV_KEY, arrow_map, VAL_RELEASE);
          cnt_d   = 2'd2;
        end
      end else if (mode == MODE_LAZY && !is_modifier(event_code_i)) begin
        meta_inj_d = 1'b1;
        if (!meta_inj_q) begin
          ev_d[0] = make_ev(EV_KEY, KC_LMETA, VAL_PRESS);
          ev_d[1] = make_ev(event_type_i, event_code_i, event_value_i);
          cnt_d   = 2'd2;
        end else begin
          pass_thru = 1'b1;
        end
      end else begin
        pass_thru = 1'b1;
      end
    end else if (event_code_i == KC_LMETA && event_value_i == VAL_PRESS) begin
      meta_held_d = 1'b1;
      meta_used_d = 1'b0;
      meta_inj_d  = 1'b0;
      pass_thru   = (mode == MODE_PASS);
    end else begin
      pass_thru = 1'b1;
    end

    if (pass_thru) begin
      ev_d[0] = make_ev(event_type_i, event_code_i, event_value_i);
      cnt_d   = 2'd1;
    end
  end

  // Advance modifier state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_held_q <= 1'b0;
      meta_used_q <= 1'b0;
      meta_inj_q  <= 1'b0;
      caps_held_q <= 1'b0;
      caps_used_q <= 1'b0;
    end else if (in_acc) begin
      meta_held_q <= meta_held_d;
      meta_used_q <= meta_used_d;
      meta_inj_q  <= meta_inj_d;
      caps_held_q <= caps_held_d;
      caps_used_q <= caps_used_d;
    end
  end

  // Load the run on accept, step through it as results are taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else if (in_acc) begin
      cnt_q <= cnt_d;
      idx_q <= 2'd0;
    end else if (out_acc) begin
      if (is_last) begin
        cnt_q <= 2'd0;
        idx_q <= 2'd0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  // Hold result payloads
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < MaxRes; i++) begin
        buf_q[i] <= ev_d[i];
      end
    end
  end

endmodule
